// ===== hdl/first_fit_free_list_allocator_unit_macros.svh =====
// Assertion macros used by the allocator unit.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define FFA_CHECK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("allocator check failed");

// Check a property on every rising edge, reset included.
`define FFA_CHECK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("allocator check failed");

`endif

// ===== hdl/ffa_pkg.sv =====
package ffa_pkg;

  localparam int MAX_FREE_SEGMENTS_DEF = 64;
  localparam int MAX_LIVE_BLOCKS_DEF   = 64;
  localparam logic [31:0] HEADER_BYTES = 32'h10;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_FREE_MEMORY_START = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLE_START        = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLE_END          = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_ADDRESS       = 8'd3;

  localparam logic [31:0] RST_FREE_MEMORY_START = 32'h0;
  localparam logic [31:0] RST_HOLE_START        = 32'h000A_0000;
  localparam logic [31:0] RST_HOLE_END          = 32'h0010_0000;
  localparam logic [31:0] RST_TOP_ADDRESS       = 32'h0040_0000;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_BADSIZE = 3'd2;
  localparam logic [2:0] ST_BADADDR = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [4:0] {
    S_RB0, S_RB1, S_IDLE,
    S_A_SLOT, S_A_RD, S_A_CHK, S_A_UPD,
    S_SH_RD, S_SH_WR,
    S_F_LRD, S_F_LCHK, S_P_RD, S_P_CHK, S_R_RD, S_R_WR, S_INS,
    S_N_RD, S_N_CHK, S_N_WR, S_PV_RD, S_PV_CHK, S_PV_WR,
    S_DONE
  } state_t;

endpackage

// ===== hdl/ffa_if.sv =====
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] alloc_size;
  logic [31:0] free_addr;
  modport source (output valid, req_type, alloc_size, free_addr, input ready);
  modport sink   (input valid, req_type, alloc_size, free_addr, output ready);
endinterface

interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] block_addr;
  logic [6:0]  free_segments;
  modport source (output valid, status, block_addr, free_segments, input ready);
  modport sink   (input valid, status, block_addr, free_segments, output ready);
endinterface

interface ffa_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/first_fit_free_list_allocator_unit.sv =====
// Channel   Dir  Word
// in_ch     in   req_type, alloc_size, free_addr
// out_ch    out  status, block_addr, free_segments
// cfg_ch    in   index, data (register write)
//
// One request at a time; a rejected request goes straight to the result, while a free or an
// alloc request walks the live table and the free-segment RAM, whose single read port serves
// one entry at a time while searching, inserting and removing.
// After reset and after each write to one of the four registers the free table is rebuilt
// in states S_RB0 and S_RB1.
// in_ch and cfg_ch are ready only when idle; a result waits in out_ch until taken.
`include "first_fit_free_list_allocator_unit_macros.svh"

module first_fit_free_list_allocator_unit import ffa_pkg::*; #(
  parameter int MAX_FREE_SEGMENTS = MAX_FREE_SEGMENTS_DEF,
  parameter int MAX_LIVE_BLOCKS   = MAX_LIVE_BLOCKS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ffa_req_if.sink   in_ch,
  ffa_rsp_if.source out_ch,
  ffa_cfg_if.sink   cfg_ch
);

  localparam int SAW = $clog2(MAX_FREE_SEGMENTS);
  localparam int CW  = $clog2(MAX_FREE_SEGMENTS + 1);
  localparam int LAW = (MAX_LIVE_BLOCKS > 1) ? $clog2(MAX_LIVE_BLOCKS) : 1;
  localparam int LCW = $clog2(MAX_LIVE_BLOCKS + 1);

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [31:0] fms_r, hs_r, he_r, ta_r;
  logic [CW-1:0] cnt_r, cnt_nxt, sidx_r, sidx_nxt, p_r, p_nxt;
  logic [LCW-1:0] lidx_r, lidx_nxt;
  logic [LAW-1:0] slot_r, slot_nxt;
  logic [MAX_LIVE_BLOCKS-1:0] lvalid_r, lvalid_nxt;
  logic [32:0] need_r, need_nxt;
  logic [31:0] addr_r, addr_nxt, bstart_r, bstart_nxt, lsize_r, lsize_nxt;
  logic [31:0] cur_start_r, cur_start_nxt, cur_size_r, cur_size_nxt;
  logic [31:0] tmp_start_r, tmp_start_nxt, tmp_size_r, tmp_size_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [31:0] baddr_r, baddr_nxt;

  logic          seg_we, live_we;
  logic [SAW-1:0] seg_waddr, seg_raddr;
  logic [63:0]   seg_wdata, seg_rdata, live_wdata, live_rdata;
  logic [LAW-1:0] live_waddr, live_raddr;

  logic [31:0] rd_start, rd_size, l_addr, l_size, m_addr, hi_addr, hi_a;
  logic        in_fire, cfg_fire, cfg_hit;
  logic [CW-1:0] sidx_p1, p_p1;
  logic        lv_cur, l_last, a_bad, f_bad, a_fit, a_exact, n_touch, pv_touch;

  assign rd_start = seg_rdata[63:32];
  assign rd_size  = seg_rdata[31:0];
  assign l_addr   = live_rdata[63:32];
  assign l_size   = live_rdata[31:0];

  // Free memory start rounded up to 16, wrapping past the top of the address space.
  assign m_addr  = (fms_r[3:0] != 4'h0) ? {fms_r[31:4] + 28'd1, 4'h0} : fms_r;
  assign hi_a    = (he_r < hs_r) ? hs_r : he_r;
  assign hi_addr = (hi_a < m_addr) ? m_addr : hi_a;

  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == S_IDLE);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign cfg_hit  = (cfg_ch.index == REG_FREE_MEMORY_START) || (cfg_ch.index == REG_HOLE_START)
                 || (cfg_ch.index == REG_HOLE_END) || (cfg_ch.index == REG_TOP_ADDRESS);

  assign sidx_p1 = sidx_r + CW'(1);
  assign p_p1    = p_r + CW'(1);
  assign lv_cur  = lvalid_r[lidx_r[LAW-1:0]];
  assign l_last  = (lidx_r == LCW'(MAX_LIVE_BLOCKS - 1));
  assign a_bad   = (in_ch.alloc_size == 32'h0) || (in_ch.alloc_size >= ta_r);
  assign f_bad   = (in_ch.free_addr == 32'h0) || (in_ch.free_addr[3:0] != 4'h0);
  assign a_fit   = (need_r <= {1'b0, rd_size});
  assign a_exact = (tmp_size_r == need_r[31:0]);
  assign n_touch = (({1'b0, cur_start_r} + {1'b0, cur_size_r}) == {1'b0, rd_start});
  assign pv_touch = (({1'b0, rd_start} + {1'b0, rd_size}) == {1'b0, cur_start_r});

  ffa_ram #(.W(64), .D(MAX_FREE_SEGMENTS), .AW(SAW)) u_seg_ram (
    .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
    .raddr(seg_raddr), .rdata(seg_rdata)
  );

  ffa_ram #(.W(64), .D(MAX_LIVE_BLOCKS), .AW(LAW)) u_live_ram (
    .clk(clk), .we(live_we), .waddr(live_waddr), .wdata(live_wdata),
    .raddr(live_raddr), .rdata(live_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RB0: state_nxt = S_RB1;
      S_RB1: state_nxt = S_IDLE;
      S_IDLE: begin
        if (cfg_fire) begin
          if (cfg_hit) state_nxt = S_RB0;
        end else if (in_fire) begin
          if (in_ch.req_type == REQ_ALLOC) state_nxt = a_bad ? S_DONE : S_A_SLOT;
          else state_nxt = f_bad ? S_DONE : S_F_LRD;
        end
      end
      S_A_SLOT: begin
        if (!lv_cur) state_nxt = S_A_RD;
        else if (l_last) state_nxt = S_DONE;
      end
      S_A_RD:   state_nxt = (sidx_r >= cnt_r) ? S_DONE : S_A_CHK;
      S_A_CHK:  state_nxt = a_fit ? S_A_UPD : S_A_RD;
      S_A_UPD:  state_nxt = a_exact ? S_SH_RD : S_DONE;
      S_SH_RD:  state_nxt = (sidx_p1 >= cnt_r) ? ret_r : S_SH_WR;
      S_SH_WR:  state_nxt = S_SH_RD;
      S_F_LRD:  state_nxt = S_F_LCHK;
      S_F_LCHK: begin
        if (lv_cur && (l_addr == addr_r)) begin
          state_nxt = (cnt_r >= CW'(MAX_FREE_SEGMENTS)) ? S_DONE : S_P_RD;
        end else begin
          state_nxt = l_last ? S_DONE : S_F_LRD;
        end
      end
      S_P_RD:   state_nxt = (sidx_r >= cnt_r) ? S_R_RD : S_P_CHK;
      S_P_CHK:  state_nxt = (rd_start < bstart_r) ? S_P_RD : S_R_RD;
      S_R_RD:   state_nxt = (sidx_r == p_r) ? S_INS : S_R_WR;
      S_R_WR:   state_nxt = S_R_RD;
      S_INS:    state_nxt = S_N_RD;
      S_N_RD:   state_nxt = (p_p1 >= cnt_r) ? S_PV_RD : S_N_CHK;
      S_N_CHK:  state_nxt = n_touch ? S_N_WR : S_PV_RD;
      S_N_WR:   state_nxt = S_SH_RD;
      S_PV_RD:  state_nxt = (p_r == '0) ? S_DONE : S_PV_CHK;
      S_PV_CHK: state_nxt = pv_touch ? S_PV_WR : S_DONE;
      S_PV_WR:  state_nxt = S_SH_RD;
      S_DONE:   state_nxt = out_ch.ready ? S_IDLE : S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    ret_nxt = ret_r;
    cnt_nxt = cnt_r;
    sidx_nxt = sidx_r;
    p_nxt = p_r;
    lidx_nxt = lidx_r;
    slot_nxt = slot_r;
    lvalid_nxt = lvalid_r;
    need_nxt = need_r;
    addr_nxt = addr_r;
    bstart_nxt = bstart_r;
    lsize_nxt = lsize_r;
    cur_start_nxt = cur_start_r;
    cur_size_nxt = cur_size_r;
    tmp_start_nxt = tmp_start_r;
    tmp_size_nxt = tmp_size_r;
    st_nxt = st_r;
    baddr_nxt = baddr_r;
    seg_we = 1'b0;
    seg_waddr = '0;
    seg_wdata = '0;
    seg_raddr = '0;
    live_we = 1'b0;
    live_waddr = slot_r;
    live_wdata = '0;
    live_raddr = lidx_r[LAW-1:0];
    unique case (state_r)
      S_RB0: begin
        seg_we = (hs_r > m_addr);
        seg_wdata = {m_addr, hs_r - m_addr};
        cnt_nxt = (hs_r > m_addr) ? CW'(1) : CW'(0);
      end
      S_RB1: begin
        if (ta_r > hi_addr) begin
          seg_we = 1'b1;
          seg_waddr = cnt_r[SAW-1:0];
          seg_wdata = {hi_addr, ta_r - hi_addr};
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_IDLE: begin
        if (cfg_fire) begin
          if (cfg_hit) lvalid_nxt = '0;
        end else if (in_fire) begin
          lidx_nxt = '0;
          baddr_nxt = 32'h0;
          if (in_ch.req_type == REQ_ALLOC) begin
            st_nxt = ST_BADSIZE;
            // Round up to 16 and add the header in one add.
            need_nxt = (in_ch.alloc_size[3:0] != 4'h0)
                     ? {({1'b0, in_ch.alloc_size[31:4]} + 29'd2), 4'h0}
                     : {1'b0, in_ch.alloc_size} + {1'b0, HEADER_BYTES};
          end else begin
            st_nxt = ST_BADADDR;
            addr_nxt = in_ch.free_addr;
            bstart_nxt = in_ch.free_addr - HEADER_BYTES;
          end
        end
      end
      S_A_SLOT: begin
        if (!lv_cur) begin
          slot_nxt = lidx_r[LAW-1:0];
          sidx_nxt = '0;
        end else if (l_last) begin
          st_nxt = ST_FULL;
        end else begin
          lidx_nxt = lidx_r + LCW'(1);
        end
      end
      S_A_RD: begin
        seg_raddr = sidx_r[SAW-1:0];
        if (sidx_r >= cnt_r) st_nxt = ST_NOFIT;
      end
      S_A_CHK: begin
        if (a_fit) begin
          tmp_start_nxt = rd_start;
          tmp_size_nxt = rd_size;
        end else begin
          sidx_nxt = sidx_p1;
        end
      end
      S_A_UPD: begin
        live_we = 1'b1;
        live_wdata = {tmp_start_r + HEADER_BYTES, need_r[31:0]};
        lvalid_nxt[slot_r] = 1'b1;
        st_nxt = ST_OK;
        baddr_nxt = tmp_start_r + HEADER_BYTES;
        if (a_exact) begin
          ret_nxt = S_DONE;
        end else begin
          seg_we = 1'b1;
          seg_waddr = sidx_r[SAW-1:0];
          seg_wdata = {tmp_start_r + need_r[31:0], tmp_size_r - need_r[31:0]};
        end
      end
      S_SH_RD: begin
        seg_raddr = sidx_p1[SAW-1:0];
        if (sidx_p1 >= cnt_r) cnt_nxt = cnt_r - CW'(1);
      end
      S_SH_WR: begin
        seg_we = 1'b1;
        seg_waddr = sidx_r[SAW-1:0];
        seg_wdata = seg_rdata;
        sidx_nxt = sidx_p1;
      end
      S_F_LRD: begin
      end
      S_F_LCHK: begin
        if (lv_cur && (l_addr == addr_r)) begin
          lsize_nxt = l_size;
          slot_nxt = lidx_r[LAW-1:0];
          sidx_nxt = '0;
          if (cnt_r >= CW'(MAX_FREE_SEGMENTS)) st_nxt = ST_FULL;
        end else if (!l_last) begin
          lidx_nxt = lidx_r + LCW'(1);
          live_raddr = LAW'(lidx_r + LCW'(1));
        end
      end
      S_P_RD: begin
        seg_raddr = sidx_r[SAW-1:0];
        if (sidx_r >= cnt_r) begin
          p_nxt = sidx_r;
          sidx_nxt = cnt_r;
        end
      end
      S_P_CHK: begin
        if (rd_start < bstart_r) begin
          sidx_nxt = sidx_p1;
        end else begin
          p_nxt = sidx_r;
          sidx_nxt = cnt_r;
        end
      end
      S_R_RD: begin
        seg_raddr = SAW'(sidx_r - CW'(1));
      end
      S_R_WR: begin
        seg_we = 1'b1;
        seg_waddr = sidx_r[SAW-1:0];
        seg_wdata = seg_rdata;
        sidx_nxt = sidx_r - CW'(1);
      end
      S_INS: begin
        seg_we = 1'b1;
        seg_waddr = p_r[SAW-1:0];
        seg_wdata = {bstart_r, lsize_r};
        cnt_nxt = cnt_r + CW'(1);
        lvalid_nxt[slot_r] = 1'b0;
        cur_start_nxt = bstart_r;
        cur_size_nxt = lsize_r;
        st_nxt = ST_OK;
      end
      S_N_RD: begin
        seg_raddr = p_p1[SAW-1:0];
      end
      S_N_CHK: begin
        tmp_size_nxt = rd_size;
      end
      S_N_WR: begin
        seg_we = 1'b1;
        seg_waddr = p_r[SAW-1:0];
        seg_wdata = {cur_start_r, cur_size_r + tmp_size_r};
        cur_size_nxt = cur_size_r + tmp_size_r;
        sidx_nxt = p_p1;
        ret_nxt = S_PV_RD;
      end
      S_PV_RD: begin
        seg_raddr = SAW'(p_r - CW'(1));
      end
      S_PV_CHK: begin
        tmp_start_nxt = rd_start;
        tmp_size_nxt = rd_size;
      end
      S_PV_WR: begin
        seg_we = 1'b1;
        seg_waddr = SAW'(p_r - CW'(1));
        seg_wdata = {tmp_start_r, tmp_size_r + cur_size_r};
        sidx_nxt = p_r;
        ret_nxt = S_DONE;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_RB0;
      ret_r    <= S_DONE;
      cnt_r    <= '0;
      lvalid_r <= '0;
      fms_r    <= RST_FREE_MEMORY_START;
      hs_r     <= RST_HOLE_START;
      he_r     <= RST_HOLE_END;
      ta_r     <= RST_TOP_ADDRESS;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      cnt_r    <= cnt_nxt;
      lvalid_r <= lvalid_nxt;
      if (cfg_fire) begin
        unique case (cfg_ch.index)
          REG_FREE_MEMORY_START: fms_r <= cfg_ch.data;
          REG_HOLE_START:        hs_r  <= cfg_ch.data;
          REG_HOLE_END:          he_r  <= cfg_ch.data;
          REG_TOP_ADDRESS:       ta_r  <= cfg_ch.data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sidx_r <= sidx_nxt;
    p_r <= p_nxt;
    lidx_r <= lidx_nxt;
    slot_r <= slot_nxt;
    need_r <= need_nxt;
    addr_r <= addr_nxt;
    bstart_r <= bstart_nxt;
    lsize_r <= lsize_nxt;
    cur_start_r <= cur_start_nxt;
    cur_size_r <= cur_size_nxt;
    tmp_start_r <= tmp_start_nxt;
    tmp_size_r <= tmp_size_nxt;
    st_r <= st_nxt;
    baddr_r <= baddr_nxt;
  end

  assign out_ch.valid         = (state_r == S_DONE);
  assign out_ch.status        = st_r;
  assign out_ch.block_addr    = baddr_r;
  assign out_ch.free_segments = 7'(cnt_r);

  `FFA_CHECK(a_ready_excl, clk, rst_n, !(in_ch.ready && out_ch.valid))
  `FFA_CHECK(a_cnt_bound, clk, rst_n, cnt_r <= CW'(MAX_FREE_SEGMENTS))
  `FFA_CHECK(a_busy_after_accept, clk, rst_n, in_fire |=> !in_ch.ready)
  `FFA_CHECK(a_fail_zero_addr, clk, rst_n, (out_ch.valid && (out_ch.status != ST_OK)) |-> (out_ch.block_addr == 32'h0))

endmodule

// ===== hdl/ffa_ram.sv =====
module ffa_ram #(
  parameter int W  = 64,
  parameter int D  = 64,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
